// ===== rtl/core/mrrd_pkg.sv =====
// ----------------------------------------------------------------------------
// mrrd_pkg
// Shared types and constants for the modem read response deframer.
// ----------------------------------------------------------------------------
package mrrd_pkg;

  localparam int unsigned HdrLen   = 10;
  localparam int unsigned TagLen   = 5;
  localparam int unsigned QueDepth = 4;
  localparam int unsigned QuePtrW  = $clog2(QueDepth);
  localparam int unsigned QueCntW  = $clog2(QueDepth + 1);

  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChD       = 8'h44;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_NOHDR  = 3'd1,
    ST_NODIG  = 3'd2,
    ST_ZERO   = 3'd3,
    ST_NONL   = 3'd4,
    ST_SHORT  = 3'd5
  } parse_status_e;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } item_kind_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_response;
  } in_item_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  payload_byte;
    logic [2:0]  parse_status;
    logic [15:0] declared_length;
    logic        is_last;
  } out_item_t;

  // results of one parse step
  typedef struct packed {
    logic pay_valid;
    logic stat_valid;
  } step_flags_t;

  typedef struct packed {
    logic               room;   // at least two free slots
    logic [QueCntW-1:0] count;
  } que_status_t;

  // "+HTTPREAD:"
  function automatic logic [7:0] hdr_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h2B;
      4'd1:    c = 8'h48;
      4'd2:    c = 8'h54;
      4'd3:    c = 8'h54;
      4'd4:    c = 8'h50;
      4'd5:    c = 8'h52;
      4'd6:    c = 8'h45;
      4'd7:    c = 8'h41;
      4'd8:    c = 8'h44;
      4'd9:    c = 8'h3A;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "DATA,"
  function automatic logic [7:0] tag_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h44;
      3'd1:    c = 8'h41;
      3'd2:    c = 8'h54;
      3'd3:    c = 8'h41;
      3'd4:    c = 8'h2C;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/mrrd_parser.sv =====
// ----------------------------------------------------------------------------
// mrrd_parser
// Header/length/payload parse state; one byte per step, up to two results.
// ----------------------------------------------------------------------------
module mrrd_parser #(
  parameter int unsigned LENGTH_WIDTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  mrrd_pkg::in_item_t  item_i,
  output mrrd_pkg::step_flags_t flags_o,
  output mrrd_pkg::out_item_t pay_item_o,
  output mrrd_pkg::out_item_t stat_item_o
);

  localparam int unsigned AccW = LENGTH_WIDTH + 4;
  localparam logic [LENGTH_WIDTH-1:0] LenMax = {LENGTH_WIDTH{1'b1}};

  typedef enum logic [7:0] {
    PH_SEARCH   = 8'b0000_0001,
    PH_SPACES   = 8'b0000_0010,
    PH_DATA     = 8'b0000_0100,
    PH_FIRSTDIG = 8'b0000_1000,
    PH_DIGITS   = 8'b0001_0000,
    PH_NEWLINE  = 8'b0010_0000,
    PH_PAYLOAD  = 8'b0100_0000,
    PH_DONE     = 8'b1000_0000
  } phase_e;

  phase_e                  phase_q, phase_d;
  logic [3:0]              match_q, match_d;
  logic [LENGTH_WIDTH-1:0] acc_q, acc_d;
  logic [LENGTH_WIDTH-1:0] remain_q, remain_d;
  logic [2:0]              err_q, err_d;

  logic [7:0]              b;
  logic                    is_digit;
  logic [AccW-1:0]         acc_ext, acc_mul;
  logic [LENGTH_WIDTH-1:0] acc_sat;
  logic [2:0]              st;

  assign b        = item_i.in_byte;
  assign is_digit = (b >= mrrd_pkg::ChZero) && (b <= mrrd_pkg::ChNine);
  assign acc_ext  = AccW'(acc_q);
  // acc*10 + digit; ASCII digits carry their value in the low nibble
  assign acc_mul  = (acc_ext << 3) + (acc_ext << 1) + AccW'(b[3:0]);
  assign acc_sat  = (acc_mul > AccW'(LenMax)) ? LenMax : acc_mul[LENGTH_WIDTH-1:0];

  always_comb begin
    phase_d  = phase_q;
    match_d  = match_q;
    acc_d    = acc_q;
    remain_d = remain_q;
    err_d    = err_q;
    flags_o  = '0;
    st       = mrrd_pkg::ST_OK;

    pay_item_o                 = '0;
    pay_item_o.item_kind       = mrrd_pkg::KIND_PAYLOAD;
    pay_item_o.payload_byte    = b;
    pay_item_o.parse_status    = mrrd_pkg::ST_OK;
    pay_item_o.declared_length = 16'(acc_q);

    case (phase_q)
      PH_SEARCH: begin
        if (b == mrrd_pkg::hdr_char(match_q)) begin
          if (match_q == 4'(mrrd_pkg::HdrLen - 1)) begin
            match_d = '0;
            phase_d = PH_SPACES;
          end else begin
            match_d = match_q + 4'd1;
          end
        end else begin
          match_d = (b == mrrd_pkg::ChPlus) ? 4'd1 : 4'd0;
        end
      end
      PH_SPACES: begin
        if (b == mrrd_pkg::ChSpace || b == mrrd_pkg::ChTab) begin
          phase_d = PH_SPACES;
        end else if (b == mrrd_pkg::ChD) begin
          match_d = 4'd1;
          phase_d = PH_DATA;
        end else if (is_digit) begin
          acc_d   = LENGTH_WIDTH'(b[3:0]);
          phase_d = PH_DIGITS;
        end else begin
          phase_d = PH_DONE;
          err_d   = mrrd_pkg::ST_NODIG;
        end
      end
      PH_DATA: begin
        if (match_q < 4'(mrrd_pkg::TagLen) && b == mrrd_pkg::tag_char(match_q[2:0])) begin
          if (match_q == 4'(mrrd_pkg::TagLen - 1)) begin
            match_d = '0;
            phase_d = PH_FIRSTDIG;
          end else begin
            match_d = match_q + 4'd1;
          end
        end else begin
          match_d = '0;
          phase_d = PH_DONE;
          err_d   = mrrd_pkg::ST_NODIG;
        end
      end
      PH_FIRSTDIG: begin
        if (is_digit) begin
          acc_d   = LENGTH_WIDTH'(b[3:0]);
          phase_d = PH_DIGITS;
        end else begin
          phase_d = PH_DONE;
          err_d   = mrrd_pkg::ST_NODIG;
        end
      end
      PH_DIGITS: begin
        if (is_digit) begin
          acc_d = acc_sat;
        end else if (acc_q == '0) begin
          phase_d = PH_DONE;
          err_d   = mrrd_pkg::ST_ZERO;
        end else if (b == mrrd_pkg::ChNewline) begin
          remain_d = acc_q;
          phase_d  = PH_PAYLOAD;
        end else begin
          phase_d = PH_NEWLINE;
        end
      end
      PH_NEWLINE: begin
        if (b == mrrd_pkg::ChNewline) begin
          remain_d = acc_q;
          phase_d  = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        flags_o.pay_valid = 1'b1;
        if (remain_q != '0) begin
          remain_d = remain_q - LENGTH_WIDTH'(1);
        end
        if (remain_q <= LENGTH_WIDTH'(1)) begin
          phase_d = PH_DONE;
          err_d   = mrrd_pkg::ST_OK;
        end
      end
      default: begin
        phase_d = phase_q;
      end
    endcase

    // status from the state after this byte
    case (phase_d)
      PH_SEARCH:   st = mrrd_pkg::ST_NOHDR;
      PH_SPACES:   st = mrrd_pkg::ST_NODIG;
      PH_DATA:     st = mrrd_pkg::ST_NODIG;
      PH_FIRSTDIG: st = mrrd_pkg::ST_NODIG;
      PH_DIGITS:   st = (acc_d == '0) ? mrrd_pkg::ST_ZERO : mrrd_pkg::ST_NONL;
      PH_NEWLINE:  st = mrrd_pkg::ST_NONL;
      PH_PAYLOAD:  st = mrrd_pkg::ST_SHORT;
      default:     st = err_d;
    endcase

    stat_item_o                 = '0;
    stat_item_o.item_kind       = mrrd_pkg::KIND_STATUS;
    stat_item_o.payload_byte    = '0;
    stat_item_o.parse_status    = st;
    stat_item_o.declared_length = 16'(acc_d);
    stat_item_o.is_last         = 1'b1;

    if (item_i.end_of_response) begin
      flags_o.stat_valid = 1'b1;
      phase_d  = PH_SEARCH;
      match_d  = '0;
      acc_d    = '0;
      remain_d = '0;
      err_d    = mrrd_pkg::ST_OK;
    end

    if (!step_i) begin
      flags_o  = '0;
      phase_d  = phase_q;
      match_d  = match_q;
      acc_d    = acc_q;
      remain_d = remain_q;
      err_d    = err_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_SEARCH;
      match_q  <= '0;
      acc_q    <= '0;
      remain_q <= '0;
      err_q    <= mrrd_pkg::ST_OK;
    end else begin
      phase_q  <= phase_d;
      match_q  <= match_d;
      acc_q    <= acc_d;
      remain_q <= remain_d;
      err_q    <= err_d;
    end
  end

endmodule

// ===== rtl/core/mrrd_out_queue.sv =====
// ----------------------------------------------------------------------------
// mrrd_out_queue
// Small result queue: takes up to two items per cycle, delivers one unless stalled.
// ----------------------------------------------------------------------------
module mrrd_out_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mrrd_pkg::step_flags_t push_i,
  input  mrrd_pkg::out_item_t   pay_item_i,
  input  mrrd_pkg::out_item_t   stat_item_i,
  output mrrd_pkg::que_status_t status_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output mrrd_pkg::out_item_t   out_item_o
);

  localparam int unsigned PtrW = mrrd_pkg::QuePtrW;
  localparam int unsigned CntW = mrrd_pkg::QueCntW;

  mrrd_pkg::out_item_t mem_q [mrrd_pkg::QueDepth];
  logic [PtrW-1:0]     wr_q, wr_d, rd_q, rd_d, stat_slot;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                pop;

  assign pop         = (cnt_q != '0) && !out_stall_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_item_o  = mem_q[rd_q];
  assign stat_slot   = wr_q + PtrW'(push_i.pay_valid);

  assign wr_d  = wr_q + PtrW'(push_i.pay_valid) + PtrW'(push_i.stat_valid);
  assign rd_d  = rd_q + PtrW'(pop);
  assign cnt_d = cnt_q + CntW'(push_i.pay_valid) + CntW'(push_i.stat_valid) - CntW'(pop);

  assign status_o.count = cnt_q;
  assign status_o.room  = (cnt_q <= CntW'(mrrd_pkg::QueDepth - 2));

  always_ff @(posedge clk_i) begin
    if (push_i.pay_valid) begin
      mem_q[wr_q] <= pay_item_i;
    end
    if (push_i.stat_valid) begin
      mem_q[stat_slot] <= stat_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== rtl/core/modem_read_response_deframer_core.sv =====
// Throughput: one byte per cycle while the result queue has room; the final byte
// of a response may give two results, which a four-entry result queue absorbs
// and drains one per cycle unless the output stalls. Input stalls only when the
// queue holds more than two items. Each accepted byte is registered first.
// Reset: asynchronous, active low; parser returns to header search, queue empties.
// ----------------------------------------------------------------------------
// modem_read_response_deframer_core
// Finds the read header, takes the decimal length and passes the payload bytes,
// closing each response with a status item.
// ----------------------------------------------------------------------------
module modem_read_response_deframer_core #(
  parameter int unsigned LENGTH_WIDTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mrrd_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mrrd_pkg::out_item_t out_item_o
);

  logic                  in_valid_q, in_valid_d;
  mrrd_pkg::in_item_t    in_q;
  logic                  accept, step;
  mrrd_pkg::step_flags_t flags;
  mrrd_pkg::out_item_t   pay_item, stat_item;
  mrrd_pkg::que_status_t que_st;

  assign step       = in_valid_q && que_st.room;
  assign in_stall_o = in_valid_q && !que_st.room;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_valid_d = accept ? 1'b1 : (step ? 1'b0 : in_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_item_i;
    end
  end

  mrrd_parser #(
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .item_i     (in_q),
    .flags_o    (flags),
    .pay_item_o (pay_item),
    .stat_item_o(stat_item)
  );

  mrrd_out_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (flags),
    .pay_item_i (pay_item),
    .stat_item_i(stat_item),
    .status_o   (que_st),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  a_que_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    que_st.count <= mrrd_pkg::QueCntW'(mrrd_pkg::QueDepth))
    else $error("result queue overflow");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.item_kind == out_item_o.is_last))
    else $error("status item and last flag disagree");

  a_payload_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.item_kind == mrrd_pkg::KIND_PAYLOAD) |->
      (out_item_o.parse_status == mrrd_pkg::ST_OK))
    else $error("payload item carries a status");

  a_step_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (flags.pay_valid || flags.stat_valid) |-> (in_valid_q && que_st.room))
    else $error("result pushed without a byte or room");

endmodule

// ===== test/modem_read_response_deframer_checker.sv =====
// ----------------------------------------------------------------------------
// modem_read_response_deframer_checker
// Watches both channels of the deframer. It keeps its own parse state, works
// out the payload and status items each accepted byte should produce, and
// compares every accepted result field by field against the oldest one.
// ----------------------------------------------------------------------------
module modem_read_response_deframer_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  mrrd_pkg::in_item_t  in_item_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  mrrd_pkg::out_item_t out_item_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [79:0] HeaderText = "+HTTPREAD:";
  localparam logic [39:0] TagText    = "DATA,";
  localparam int unsigned LengthMax  = 32'h0000_FFFF;

  typedef enum logic [2:0] {
    SEEK_HEADER,
    SKIP_BLANKS,
    MATCH_TAG,
    FIRST_DIGIT,
    READ_DIGITS,
    SEEK_NEWLINE,
    PASS_PAYLOAD,
    IGNORE_REST
  } parse_phase_e;

  parse_phase_e            phase;
  logic [3:0]              match_pos;
  logic [15:0]             length_acc;
  logic [15:0]             remaining;
  mrrd_pkg::parse_status_e err_code;
  mrrd_pkg::out_item_t     expected_q[$];
  int unsigned             fail_count = 0;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic void clear_parser();
    phase      = SEEK_HEADER;
    match_pos  = '0;
    length_acc = '0;
    remaining  = '0;
    err_code   = mrrd_pkg::ST_OK;
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic [15:0] add_digit(logic [15:0] acc, logic [7:0] b);
    int unsigned v;
    v = 32'(acc) * 32'd10 + 32'(b) - 32'h30;
    if (v > LengthMax) v = LengthMax;
    return v[15:0];
  endfunction

  function automatic void abort_parse(mrrd_pkg::parse_status_e code);
    phase    = IGNORE_REST;
    err_code = code;
  endfunction

  // advance the parser by one byte and queue whatever items it yields
  function automatic void predict_byte(logic [7:0] b, logic eor);
    mrrd_pkg::parse_status_e st;
    case (phase)
      SEEK_HEADER: begin
        if (b == HeaderText[8*(mrrd_pkg::HdrLen-1-match_pos) +: 8]) begin
          if (match_pos == 4'(mrrd_pkg::HdrLen - 1)) begin
            match_pos = '0;
            phase     = SKIP_BLANKS;
          end else begin
            match_pos++;
          end
        end else begin
          match_pos = (b == "+") ? 4'd1 : 4'd0;
        end
      end
      SKIP_BLANKS: begin
        if (b == " " || b == "\t") begin
        end else if (b == "D") begin
          match_pos = 4'd1;
          phase     = MATCH_TAG;
        end else if (is_digit(b)) begin
          length_acc = add_digit(16'd0, b);
          phase      = READ_DIGITS;
        end else begin
          abort_parse(mrrd_pkg::ST_NODIG);
        end
      end
      MATCH_TAG: begin
        if (b == TagText[8*(mrrd_pkg::TagLen-1-match_pos) +: 8]) begin
          if (match_pos == 4'(mrrd_pkg::TagLen - 1)) begin
            match_pos = '0;
            phase     = FIRST_DIGIT;
          end else begin
            match_pos++;
          end
        end else begin
          match_pos = '0;
          abort_parse(mrrd_pkg::ST_NODIG);
        end
      end
      FIRST_DIGIT: begin
        if (is_digit(b)) begin
          length_acc = add_digit(16'd0, b);
          phase      = READ_DIGITS;
        end else begin
          abort_parse(mrrd_pkg::ST_NODIG);
        end
      end
      READ_DIGITS: begin
        if (is_digit(b)) begin
          length_acc = add_digit(length_acc, b);
        end else if (length_acc == 0) begin
          abort_parse(mrrd_pkg::ST_ZERO);
        end else if (b == "\n") begin
          remaining = length_acc;
          phase     = PASS_PAYLOAD;
        end else begin
          phase = SEEK_NEWLINE;
        end
      end
      SEEK_NEWLINE: begin
        if (b == "\n") begin
          remaining = length_acc;
          phase     = PASS_PAYLOAD;
        end
      end
      PASS_PAYLOAD: begin
        expected_q.push_back('{item_kind: mrrd_pkg::KIND_PAYLOAD, payload_byte: b,
                               parse_status: mrrd_pkg::ST_OK,
                               declared_length: length_acc, is_last: 1'b0});
        if (remaining != 0) remaining--;
        if (remaining == 0) abort_parse(mrrd_pkg::ST_OK);
      end
      default: begin
      end
    endcase

    if (eor) begin
      case (phase)
        SEEK_HEADER:  st = mrrd_pkg::ST_NOHDR;
        SKIP_BLANKS,
        MATCH_TAG,
        FIRST_DIGIT:  st = mrrd_pkg::ST_NODIG;
        READ_DIGITS:  st = (length_acc == 0) ? mrrd_pkg::ST_ZERO : mrrd_pkg::ST_NONL;
        SEEK_NEWLINE: st = mrrd_pkg::ST_NONL;
        PASS_PAYLOAD: st = mrrd_pkg::ST_SHORT;
        default:      st = err_code;
      endcase
      expected_q.push_back('{item_kind: mrrd_pkg::KIND_STATUS, payload_byte: 8'h00,
                             parse_status: st, declared_length: length_acc,
                             is_last: 1'b1});
      clear_parser();
    end
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    mrrd_pkg::out_item_t exp_item;
    if (!rst_ni) begin
      clear_parser();
      expected_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i)
        predict_byte(in_item_i.in_byte, in_item_i.end_of_response);

      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result item: kind %0d byte %0d status %0d",
                 out_item_i.item_kind, out_item_i.payload_byte,
                 out_item_i.parse_status);
          fail_count++;
        end else begin
          exp_item = expected_q.pop_front();
          check_field("item_kind", exp_item.item_kind, out_item_i.item_kind);
          check_field("payload_byte", exp_item.payload_byte, out_item_i.payload_byte);
          check_field("parse_status", exp_item.parse_status, out_item_i.parse_status);
          check_field("declared_length", exp_item.declared_length,
                      out_item_i.declared_length);
          check_field("is_last", exp_item.is_last, out_item_i.is_last);
        end
      end
    end
    fail_count_o <= fail_count;
    pending_o    <= expected_q.size();
  end

endmodule

// ===== test/tb_modem_read_response_deframer_core.sv =====
// ----------------------------------------------------------------------------
// tb_modem_read_response_deframer_core
// Feeds whole read responses to the deframer: a directed set covering each
// header, length and ending case, then random responses, mostly well formed,
// under several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_modem_read_response_deframer_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned PhaseBytes    = 40;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  mrrd_pkg::in_item_t  in_item_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  mrrd_pkg::out_item_t out_item_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned quiet_cycles = 0;
  int unsigned bytes_sent   = 0;
  logic [7:0]  resp_bytes[$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  modem_read_response_deframer_core i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_item_i,
    .out_valid_o,
    .out_stall_i,
    .out_item_o
  );

  modem_read_response_deframer_checker i_checker (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_i   (in_stall_o),
    .in_item_i,
    .out_valid_i  (out_valid_o),
    .out_stall_i,
    .out_item_i   (out_item_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(negedge clk_i) begin
    out_stall_i <= rst_ni && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] b, input logic eor);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= '{in_byte: b, end_of_response: eor};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic void append_text(string s);
    for (int i = 0; i < s.len(); i++) resp_bytes.push_back(s[i]);
  endfunction

  task automatic send_response();
    for (int i = 0; i < resp_bytes.size(); i++)
      send_byte(resp_bytes[i], i == resp_bytes.size() - 1);
    bytes_sent += resp_bytes.size();
    resp_bytes.delete();
  endtask

  task automatic send_text(string s);
    append_text(s);
    send_response();
  endtask

  task automatic build_random_response();
    int unsigned len_v;
    int unsigned n_pay;
    int unsigned roll;
    int unsigned keep;
    string       digits;
    roll = $urandom_range(99);
    if (roll < 12) begin
      // plain noise, sometimes with stray header starts
      repeat ($urandom_range(1, 8))
        resp_bytes.push_back(($urandom_range(3) == 0) ? 8'h2B : 8'($urandom));
      return;
    end
    repeat ($urandom_range(0, 3))
      resp_bytes.push_back(($urandom_range(3) == 0) ? 8'h2B : 8'($urandom));
    append_text("+HTTPREAD:");
    repeat ($urandom_range(0, 2))
      resp_bytes.push_back($urandom_range(1) ? 8'h20 : 8'h09);
    if ($urandom_range(1)) append_text("DATA,");
    roll = $urandom_range(99);
    if (roll < 8)       len_v = 0;
    else if (roll < 14) len_v = $urandom_range(65530, 999999);
    else                len_v = $urandom_range(1, 12);
    digits = $sformatf("%0d", len_v);
    if ($urandom_range(4) == 0) digits = {"0", digits};
    append_text(digits);
    if ($urandom_range(4) == 0) append_text("\r");
    if ($urandom_range(9) != 0) append_text("\n");
    roll = $urandom_range(99);
    if (len_v > 20)     n_pay = $urandom_range(0, 6);
    else if (roll < 60) n_pay = len_v;
    else if (roll < 80) n_pay = $urandom_range(0, len_v);
    else                n_pay = len_v + $urandom_range(1, 3);
    repeat (n_pay) resp_bytes.push_back(8'($urandom));
    if ($urandom_range(9) == 0)
      resp_bytes[$urandom_range(0, resp_bytes.size() - 1)] = 8'($urandom);
    if ($urandom_range(9) == 0) begin
      keep = $urandom_range(1, resp_bytes.size());
      while (resp_bytes.size() > keep) void'(resp_bytes.pop_back());
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed responses
    send_text("X");
    send_text("+HTTPRE");
    send_text("+HTTPREAD: DATA,3\nabcXY");
    send_text("+HTTPREAD:\t 2\r\nhi");
    send_text("++HTTPREAD:5\nab");
    send_text("+HTTP+HTTPREAD:1\nZ");
    send_text("+HTTPREAD: DAX1\n");
    send_text("+HTTPREAD: DAT");
    send_text("+HTTPREAD: x");
    send_text("+HTTPREAD:");
    send_text("+HTTPREAD: DATA,");
    send_text("+HTTPREAD: DATA,x");
    send_text("+HTTPREAD: 000\nabc");
    send_text("+HTTPREAD: 00");
    send_text("+HTTPREAD: 12");
    send_text("+HTTPREAD: 12 abc");
    send_text("+HTTPREAD: 999999\nab");
    send_text("+HTTPREAD:65535\nA");
    send_text("+HTTPREAD:65536\nA");
    send_text("+HTTPREAD:1\n");
    send_text("+HTTPREAD:1\nQ");
    append_text("+HTTPREAD:2\n");
    resp_bytes.push_back(8'h00);
    resp_bytes.push_back(8'hFF);
    send_response();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 77; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 77; end
        default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      bytes_sent = 0;
      while (bytes_sent < PhaseBytes) begin
        build_random_response();
        send_response();
      end
    end

    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
